/* rtl/core/lfc_pkg.sv */
// Package for the link frame checker: header constants, status codes,
// result record and the byte-wide CRC-16/CCITT-FALSE update function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfc_pkg;

  localparam int unsigned HdrBytes   = 19;
  localparam int unsigned HdrCrcSpan = 15;
  localparam int unsigned HdrIdxW    = $clog2(HdrBytes);
  localparam int unsigned CountW     = 11;

  localparam logic [CountW-1:0] CountMax   = '1;
  localparam logic [15:0]       CrcInit    = 16'hFFFF;
  localparam logic [15:0]       CrcPoly    = 16'h1021;
  localparam logic [7:0]        MagicFirst = 8'h4D;
  localparam logic [7:0]        MagicSecond = 8'h48;
  localparam logic [7:0]        VersionRst = 8'd2;

  localparam int unsigned OffVersion = 2;
  localparam int unsigned OffHdrLen  = 3;
  localparam int unsigned OffType    = 4;
  localparam int unsigned OffFlags   = 5;
  localparam int unsigned OffSource  = 6;
  localparam int unsigned OffDest    = 7;
  localparam int unsigned OffTtl     = 8;
  localparam int unsigned OffSeq     = 9;
  localparam int unsigned OffAck     = 11;
  localparam int unsigned OffPlen    = 13;
  localparam int unsigned OffHdrCrc  = 15;
  localparam int unsigned OffPayCrc  = 17;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBadMagic   = 3'd1,
    StBadVersion = 3'd2,
    StBadLength  = 3'd3,
    StBadCrc     = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  version_seen;
    logic [7:0]  frame_type;
    logic [7:0]  flag_bits;
    logic [7:0]  source_addr;
    logic [7:0]  dest_addr;
    logic [7:0]  hops_left;
    logic [15:0] sequence_res;
    logic [15:0] acknowledge;
    logic [10:0] payload_length;
  } result_t;

  // Handshake between the input register and the frame checker.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lfc_intf.sv */
// Channel interfaces of the link frame checker: byte input, result output
// and the configuration write channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink (input valid, data_byte, frame_end, output ready);
endinterface

interface lfc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  version_seen;
  logic [7:0]  frame_type;
  logic [7:0]  flag_bits;
  logic [7:0]  source_addr;
  logic [7:0]  dest_addr;
  logic [7:0]  hops_left;
  logic [15:0] sequence_res;
  logic [15:0] acknowledge;
  logic [10:0] payload_length;

  modport source (output valid, status, version_seen, frame_type, flag_bits, source_addr,
                  dest_addr, hops_left, sequence_res, acknowledge, payload_length,
                  input ready);
  modport sink (input valid, status, version_seen, frame_type, flag_bits, source_addr,
                dest_addr, hops_left, sequence_res, acknowledge, payload_length,
                output ready);
endinterface

interface lfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] expected_version;

  modport source (output valid, expected_version, input ready);
  modport sink (input valid, expected_version, output ready);
endinterface

`default_nettype wire

/* rtl/core/lfc_in_reg.sv */
// Input register of the link frame checker: holds one byte transfer until
// the frame checker consumes it. Depends on lfc_pkg and lfc_intf.
`timescale 1ns / 1ps
`default_nettype none

module lfc_in_reg
  import lfc_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  lfc_byte_if.sink    in_i,
  input  wire         advance_i,
  output stage_ctrl_t ctrl_o,
  output in_item_t    item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{data_byte: in_i.data_byte, frame_end: in_i.frame_end};
    end
  end

  assign ctrl_o.valid   = valid_q;
  assign ctrl_o.advance = advance_i;
  assign item_o         = item_q;

endmodule

`default_nettype wire

/* rtl/core/lfc_frame_check.sv */
// Frame state and checks: byte count, both CRC accumulators, the header
// store and the verdict formed on the last byte. Depends on lfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfc_frame_check
  import lfc_pkg::*;
#(
  parameter int unsigned MaxPayload = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  stage_ctrl_t ctrl_i,
  input  in_item_t    item_i,
  input  wire [7:0]   expected_version_i,
  output result_t     result_o
);

  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [15:0]       hcrc_q, hcrc_d, hcrc_upd;
  logic [15:0]       pcrc_q, pcrc_d, pcrc_upd;
  logic [7:0]        header_q [HdrBytes];
  logic [7:0]        hdr [HdrBytes];
  logic              in_header, in_hcrc;
  logic [15:0]       hdr_crc, pay_crc, plen;
  logic [16:0]       expect_len;
  status_e           status;

  assign in_header = count_q < CountW'(HdrBytes);
  assign in_hcrc   = count_q < CountW'(HdrCrcSpan);
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;
  assign hcrc_upd  = in_hcrc ? crc16_byte(hcrc_q, item_i.data_byte) : hcrc_q;
  assign pcrc_upd  = in_header ? pcrc_q : crc16_byte(pcrc_q, item_i.data_byte);

  // The byte in flight is merged into the header view so that the verdict
  // sees the same store that the register will hold after this cycle.
  always_comb begin
    for (int i = 0; i < HdrBytes; i++) begin
      hdr[i] = (count_q == CountW'(i)) ? item_i.data_byte : header_q[i];
    end
  end

  assign hdr_crc    = {hdr[OffHdrCrc + 1], hdr[OffHdrCrc]};
  assign pay_crc    = {hdr[OffPayCrc + 1], hdr[OffPayCrc]};
  assign plen       = {hdr[OffPlen + 1], hdr[OffPlen]};
  assign expect_len = 17'(HdrBytes) + {1'b0, plen};

  always_comb begin
    if (count_inc < CountW'(HdrBytes)) begin
      status = StBadLength;
    end else if (hdr[0] != MagicFirst || hdr[1] != MagicSecond) begin
      status = StBadMagic;
    end else if (hdr[OffVersion] != expected_version_i) begin
      status = StBadVersion;
    end else if (hdr[OffHdrLen] != 8'(HdrBytes)) begin
      status = StBadLength;
    end else if (hdr_crc != hcrc_upd) begin
      status = StBadCrc;
    end else if (plen > 16'(MaxPayload)) begin
      status = StBadLength;
    end else if ({6'd0, count_inc} != expect_len) begin
      status = StBadLength;
    end else if (pay_crc != pcrc_upd) begin
      status = StBadCrc;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    result_o = '0;
    result_o.status = status;
    if (status == StOk) begin
      result_o.version_seen   = hdr[OffVersion];
      result_o.frame_type     = hdr[OffType];
      result_o.flag_bits      = hdr[OffFlags];
      result_o.source_addr    = hdr[OffSource];
      result_o.dest_addr      = hdr[OffDest];
      result_o.hops_left      = hdr[OffTtl];
      result_o.sequence_res   = {hdr[OffSeq + 1], hdr[OffSeq]};
      result_o.acknowledge    = {hdr[OffAck + 1], hdr[OffAck]};
      result_o.payload_length = plen[10:0];
    end
  end

  always_comb begin
    count_d = count_q;
    hcrc_d  = hcrc_q;
    pcrc_d  = pcrc_q;
    if (ctrl_i.advance) begin
      if (item_i.frame_end) begin
        count_d = '0;
        hcrc_d  = CrcInit;
        pcrc_d  = CrcInit;
      end else begin
        count_d = count_inc;
        hcrc_d  = hcrc_upd;
        pcrc_d  = pcrc_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hcrc_q  <= CrcInit;
      pcrc_q  <= CrcInit;
    end else begin
      count_q <= count_d;
      hcrc_q  <= hcrc_d;
      pcrc_q  <= pcrc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance && in_header) begin
      header_q[count_q[HdrIdxW-1:0]] <= item_i.data_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lfc_out_reg.sv */
// Result register of the link frame checker: holds one verdict until the
// downstream side takes it. Depends on lfc_pkg and lfc_intf.
`timescale 1ns / 1ps
`default_nettype none

module lfc_out_reg
  import lfc_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          load_i,
  input  result_t      result_i,
  output logic         free_o,
  lfc_result_if.source res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i ? 1'b1 : (res_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.status         = res_q.status;
  assign res_o.version_seen   = res_q.version_seen;
  assign res_o.frame_type     = res_q.frame_type;
  assign res_o.flag_bits      = res_q.flag_bits;
  assign res_o.source_addr    = res_q.source_addr;
  assign res_o.dest_addr      = res_q.dest_addr;
  assign res_o.hops_left      = res_q.hops_left;
  assign res_o.sequence_res   = res_q.sequence_res;
  assign res_o.acknowledge    = res_q.acknowledge;
  assign res_o.payload_length = res_q.payload_length;

endmodule

`default_nettype wire

/* rtl/core/link_frame_checker_unit.sv */
// Top level of the link frame checker.
// Depends on lfc_pkg, lfc_intf, lfc_in_reg, lfc_frame_check and lfc_out_reg.
//
// The checker takes one frame byte per transfer and accepts a byte in every
// cycle unless a last byte waits in the input register until the result
// register is free. A last byte's verdict goes into the result register,
// which presents a single result; a result waiting there does not hold up
// further bytes until the next last byte arrives. The rate of one byte per
// cycle is set by the byte-wide CRC-16/CCITT-FALSE update that sits between
// the input and result registers with the header checks. The expected
// version register resets to 2 and its write channel is always ready.
`timescale 1ns / 1ps
`default_nettype none

module link_frame_checker_unit
  import lfc_pkg::*;
#(
  parameter int unsigned MaxPayload = 1024
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  lfc_byte_if.sink     in_i,
  lfc_cfg_if.sink      cfg_i,
  lfc_result_if.source res_o
);

  stage_ctrl_t ctrl;
  in_item_t    item;
  result_t     result;
  logic        out_free;
  logic        advance;
  logic [7:0]  version_q;

  assign advance = ctrl.valid && (!item.frame_end || out_free);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VersionRst;
    end else if (cfg_i.valid) begin
      version_q <= cfg_i.expected_version;
    end
  end

  lfc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .ctrl_o    (ctrl),
    .item_o    (item)
  );

  lfc_frame_check #(
    .MaxPayload (MaxPayload)
  ) u_frame_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .item_i             (item),
    .expected_version_i (version_q),
    .result_o           (result)
  );

  lfc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && item.frame_end),
    .result_i (result),
    .free_o   (out_free),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire

/* tb/sv/link_frame_checker_unit_tb.sv */
// Self-checking testbench for link_frame_checker_unit: frame bytes go in with random gaps,
// and every verdict is compared against a predicted result held in a small scoreboard.
// Depends on lfc_pkg, the lfc_intf interfaces and the link_frame_checker_unit RTL.
`timescale 1ns / 1ps

import lfc_pkg::*;

class frame_board #(int PayloadCap = 1024);
  localparam int HeaderLen = 19;
  localparam int CrcSpan = 15;
  localparam logic [10:0] CountTop = 11'h7FF;

  logic [7:0]  want_version;
  logic [10:0] seen_count;
  logic [15:0] hdr_crc;
  logic [15:0] pay_crc;
  logic [7:0]  hdr_copy [HeaderLen];
  result_t     pending_q [$];
  int unsigned mismatches;
  int unsigned failures;

  function new();
    want_version = 8'd2;
    foreach (hdr_copy[i]) hdr_copy[i] = 8'h00;
    restart();
    mismatches = 0;
    failures = 0;
  endfunction

  static function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ 16'h1021;
    end
    return r;
  endfunction

  function void restart();
    seen_count = '0;
    hdr_crc = 16'hFFFF;
    pay_crc = 16'hFFFF;
  endfunction

  function status_e judge();
    logic [15:0] plen;
    plen = {hdr_copy[14], hdr_copy[13]};
    if (seen_count < HeaderLen) return StBadLength;
    if (hdr_copy[0] != 8'h4D || hdr_copy[1] != 8'h48) return StBadMagic;
    if (hdr_copy[2] != want_version) return StBadVersion;
    if (hdr_copy[3] != HeaderLen) return StBadLength;
    if ({hdr_copy[16], hdr_copy[15]} != hdr_crc) return StBadCrc;
    if (int'(plen) > PayloadCap) return StBadLength;
    if (int'(seen_count) != HeaderLen + int'(plen)) return StBadLength;
    if ({hdr_copy[18], hdr_copy[17]} != pay_crc) return StBadCrc;
    return StOk;
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    result_t r;
    status_e st;
    if (seen_count < HeaderLen) hdr_copy[seen_count] = b;
    if (seen_count < CrcSpan) hdr_crc = crc_step(hdr_crc, b);
    if (seen_count >= HeaderLen) pay_crc = crc_step(pay_crc, b);
    if (seen_count != CountTop) seen_count = seen_count + 11'd1;
    if (last) begin
      st = judge();
      r = '0;
      r.status = st;
      if (st == StOk) begin
        r.version_seen = hdr_copy[2];
        r.frame_type = hdr_copy[4];
        r.flag_bits = hdr_copy[5];
        r.source_addr = hdr_copy[6];
        r.dest_addr = hdr_copy[7];
        r.hops_left = hdr_copy[8];
        r.sequence_res = {hdr_copy[10], hdr_copy[9]};
        r.acknowledge = {hdr_copy[12], hdr_copy[11]};
        r.payload_length = {hdr_copy[14][2:0], hdr_copy[13]};
      end
      pending_q.push_back(r);
      restart();
    end
  endfunction

  function string show(result_t r);
    return $sformatf("st=%0d ver=%h type=%h flags=%h src=%h dst=%h ttl=%h seq=%h ack=%h len=%0d",
                     r.status, r.version_seen, r.frame_type, r.flag_bits, r.source_addr,
                     r.dest_addr, r.hops_left, r.sequence_res, r.acknowledge,
                     r.payload_length);
  endfunction

  function void check_result(result_t got);
    result_t want;
    bit bad;
    if (pending_q.size() == 0) begin
      if (mismatches < 10) $display("result with none expected: %s", show(got));
      mismatches++;
      failures++;
      return;
    end
    want = pending_q.pop_front();
    bad = (got.status !== want.status) || (got.version_seen !== want.version_seen) ||
          (got.frame_type !== want.frame_type) || (got.flag_bits !== want.flag_bits) ||
          (got.source_addr !== want.source_addr) || (got.dest_addr !== want.dest_addr) ||
          (got.hops_left !== want.hops_left) || (got.sequence_res !== want.sequence_res) ||
          (got.acknowledge !== want.acknowledge) ||
          (got.payload_length !== want.payload_length);
    if (bad) begin
      if (mismatches < 10) begin
        $display("result mismatch: expected %s", show(want));
        $display("                 actual   %s", show(got));
      end
      mismatches++;
      failures++;
    end
  endfunction
endclass

module link_frame_checker_unit_tb;
  localparam int MaxPay = 1024;
  localparam int HalfPeriod = 2;

  typedef enum int {
    FlawNone,
    FlawMagic,
    FlawVersion,
    FlawHdrLen,
    FlawHdrCrc,
    FlawPlenBig,
    FlawCount,
    FlawPayCrc,
    FlawShort,
    FlawLong
  } flaw_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  lfc_byte_if   in_if ();
  lfc_cfg_if    cfg_if ();
  lfc_result_if res_if ();

  frame_board #(MaxPay) board;
  logic [7:0] frame_q [$];

  link_frame_checker_unit #(
    .MaxPayload(MaxPay)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic last, input bit calm);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.frame_end <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.note_byte(b, last);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input bit calm);
    for (int i = 0; i < frame_q.size(); i++) begin
      put_byte(frame_q[i], i == frame_q.size() - 1, calm);
    end
  endtask

  // A negative fill gives random header fields and payload, otherwise every such byte is fill.
  task automatic build_frame(input logic [7:0] ver, input int plen, input flaw_e flaw,
                             input int fill);
    logic [7:0]  hdr [19];
    logic [7:0]  pay_q [$];
    logic [15:0] crc;
    logic [15:0] plen_field;
    int pay_n;
    int pick;
    frame_q.delete();
    hdr[0] = 8'h4D;
    hdr[1] = 8'h48;
    hdr[2] = ver;
    hdr[3] = 8'd19;
    for (int i = 4; i <= 12; i++) hdr[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    plen_field = 16'(plen);
    pay_n = plen;
    case (flaw)
      FlawMagic: begin
        pick = $urandom_range(0, 2);
        if (pick != 1) hdr[0] = hdr[0] ^ 8'($urandom_range(1, 255));
        if (pick != 0) hdr[1] = hdr[1] ^ 8'($urandom_range(1, 255));
      end
      FlawVersion: hdr[2] = ver ^ 8'($urandom_range(1, 255));
      FlawHdrLen: hdr[3] = 8'd19 ^ 8'($urandom_range(1, 255));
      FlawPlenBig: pay_n = $urandom_range(0, 6);
      FlawCount: begin
        if (plen > 0 && $urandom_range(0, 1) == 1) begin
          pay_n = plen - $urandom_range(1, (plen < 3) ? plen : 3);
        end else begin
          pay_n = plen + $urandom_range(1, 3);
        end
      end
      FlawLong: pay_n = $urandom_range(2030, 2080);
      default: ;
    endcase
    hdr[13] = plen_field[7:0];
    hdr[14] = plen_field[15:8];
    crc = 16'hFFFF;
    for (int i = 0; i < 15; i++) crc = board.crc_step(crc, hdr[i]);
    hdr[15] = crc[7:0];
    hdr[16] = crc[15:8];
    crc = 16'hFFFF;
    for (int i = 0; i < pay_n; i++) begin
      pay_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      crc = board.crc_step(crc, pay_q[i]);
    end
    hdr[17] = crc[7:0];
    hdr[18] = crc[15:8];
    if (flaw == FlawHdrCrc) begin
      pick = $urandom_range(4, 16);
      hdr[pick] = hdr[pick] ^ 8'($urandom_range(1, 255));
    end
    if (flaw == FlawPayCrc) begin
      pick = $urandom_range(17, 18);
      hdr[pick] = hdr[pick] ^ 8'($urandom_range(1, 255));
    end
    foreach (hdr[i]) frame_q.push_back(hdr[i]);
    foreach (pay_q[i]) frame_q.push_back(pay_q[i]);
    if (flaw == FlawShort) begin
      pick = $urandom_range(1, 18);
      frame_q = frame_q[0:pick-1];
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.expected_version <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    board.want_version = v;
  endtask

  task automatic run_traffic(input int budget);
    int sent;
    int r;
    int plen;
    flaw_e flaw;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      plen = $urandom_range(0, 99);
      plen = (plen < 85) ? $urandom_range(0, 16) :
             (plen < 98) ? $urandom_range(17, 120) : $urandom_range(121, MaxPay);
      if (r < 60) begin
        flaw = FlawNone;
      end else if (r < 90) begin
        flaw = flaw_e'($urandom_range(FlawMagic, FlawPayCrc));
        if (flaw == FlawPlenBig) plen = $urandom_range(MaxPay + 1, 65535);
      end else if (r < 95) begin
        flaw = FlawShort;
      end else begin
        flaw = FlawNone;
      end
      if (r < 95) begin
        build_frame(board.want_version, plen, flaw, -1);
      end else begin
        frame_q.delete();
        repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
      end
      send_frame($urandom_range(0, 3) == 0);
      sent += frame_q.size();
    end
    settle();
  endtask

  initial begin
    int stall_left;
    int calm_left;
    result_t got;
    stall_left = 0;
    calm_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.status = status_e'(res_if.status);
        got.version_seen = res_if.version_seen;
        got.frame_type = res_if.frame_type;
        got.flag_bits = res_if.flag_bits;
        got.source_addr = res_if.source_addr;
        got.dest_addr = res_if.dest_addr;
        got.hops_left = res_if.hops_left;
        got.sequence_res = res_if.sequence_res;
        got.acknowledge = res_if.acknowledge;
        got.payload_length = res_if.payload_length;
        board.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 49) == 0) begin
        calm_left = $urandom_range(50, 200);
      end else begin
        stall_left = pick_gap();
      end
      res_if.ready <= (stall_left == 0);
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.frame_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.expected_version = 8'h00;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames against the version held at reset.
    build_frame(8'd2, 0, FlawNone, 0);
    send_frame(1'b1);
    build_frame(8'd2, 1, FlawNone, 255);
    send_frame(1'b1);
    build_frame(8'd2, 7, FlawNone, -1);
    send_frame(1'b0);
    build_frame(8'd2, 0, FlawNone, 255);
    frame_q = frame_q[0:0];
    send_frame(1'b0);
    build_frame(8'd2, 0, FlawNone, -1);
    frame_q = frame_q[0:17];
    send_frame(1'b1);
    build_frame(8'd2, 2, FlawMagic, -1);
    send_frame(1'b0);
    build_frame(8'd2, 2, FlawMagic, -1);
    send_frame(1'b1);
    build_frame(8'd2, 2, FlawVersion, -1);
    send_frame(1'b0);
    build_frame(8'd2, 2, FlawHdrLen, -1);
    send_frame(1'b0);
    build_frame(8'd2, 2, FlawHdrCrc, -1);
    send_frame(1'b1);
    build_frame(8'd2, MaxPay + 1, FlawPlenBig, -1);
    send_frame(1'b0);
    build_frame(8'd2, 65535, FlawPlenBig, -1);
    send_frame(1'b0);
    build_frame(8'd2, 4, FlawCount, -1);
    send_frame(1'b1);
    build_frame(8'd2, 4, FlawCount, -1);
    send_frame(1'b0);
    build_frame(8'd2, 3, FlawPayCrc, -1);
    send_frame(1'b0);
    build_frame(8'd2, MaxPay, FlawNone, -1);
    send_frame(1'b0);
    build_frame(8'd2, MaxPay, FlawLong, -1);
    send_frame(1'b1);
    build_frame(8'd2, 5, FlawNone, -1);
    send_frame(1'b0);
    settle();

    write_version(8'hFF);
    run_traffic(340);
    write_version(8'h00);
    run_traffic(340);
    write_version(8'($urandom_range(1, 254)));
    run_traffic(340);
    write_version(8'd2);
    run_traffic(330);

    if (board.failures == 0) begin
      $display("link_frame_checker_unit_tb OK");
    end else begin
      $display("link_frame_checker_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("link_frame_checker_unit_tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lfc_pkg.sv
rtl/core/lfc_intf.sv
rtl/core/lfc_in_reg.sv
rtl/core/lfc_frame_check.sv
rtl/core/lfc_out_reg.sv
rtl/core/link_frame_checker_unit.sv
tb/sv/link_frame_checker_unit_tb.sv
